// ----- rtl/sto_pkg.sv -----
// Shared codes and controller/datapath interface types for the sorted timeout queue.
package sto_pkg;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_ADD_NOW = 2'd1;
  localparam logic [1:0] CMD_DELETE  = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EXPIRED  = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  typedef struct packed {
    logic load;
    logic rd;
    logic search;
    logic proc;
    logic tail;
    logic commit;
    logic finish;
    logic rewind;
    logic set_full;
  } sto_cmd_t;

  typedef struct packed {
    logic skip;
    logic need_search;
    logic hit;
    logic last_elem;
    logic more;
    logic stall;
    logic tail_busy;
    logic out_free;
    logic carry_v;
  } sto_stat_t;

endpackage

// ----- rtl/sto_ctrl.sv -----
// Sequencer that steps the datapath through the table scans of each command.
module sto_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sto_pkg::sto_stat_t stat_i,
  output sto_pkg::sto_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SRD, S_SPROC, S_RD, S_PROC, S_TAIL, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.skip) begin
          state_d = S_FIN;
        end else if (stat_i.need_search) begin
          state_d = S_SRD;
        end else begin
          state_d = S_RD;
        end
      end
      S_SRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SPROC;
      end
      S_SPROC: begin
        // A full table only takes the add if an entry is being replaced.
        cmd_o.search = 1'b1;
        if (stat_i.hit) begin
          cmd_o.rewind = 1'b1;
          state_d      = S_RD;
        end else if (stat_i.last_elem) begin
          cmd_o.set_full = 1'b1;
          state_d        = S_FIN;
        end else begin
          state_d = S_SRD;
        end
      end
      S_RD: begin
        if (stat_i.more) begin
          cmd_o.rd = 1'b1;
          state_d  = S_PROC;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_PROC: begin
        if (!stat_i.stall) begin
          cmd_o.proc = 1'b1;
          state_d    = S_RD;
        end
      end
      S_TAIL: begin
        if (stat_i.tail_busy) begin
          cmd_o.tail = 1'b1;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/sto_dp.sv -----
// Entry memory, time, immediate slot, compaction pass and output register.
module sto_dp #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sto_pkg::sto_cmd_t  cmd_i,
  output sto_pkg::sto_stat_t stat_o,
  input  logic [1:0]         command_i,
  input  logic [7:0]         callback_tag_i,
  input  logic [15:0]        owner_tag_i,
  input  logic [7:0]         queue_id_i,
  input  logic [31:0]        delay_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [7:0]         fired_callback_o,
  output logic [15:0]        fired_owner_o,
  output logic [7:0]         fired_queue_o,
  output logic               last_o
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int EW = TIME_BITS + 32;

  logic [EW-1:0] mem [ENTRIES];
  logic [EW-1:0] rd_q;

  logic [TIME_BITS-1:0] time_q, when_q;
  logic [CW-1:0]        cnt_q, r_q, w_q;
  logic [7:0]           cb_q, grp_q;
  logic [15:0]          ow_q;
  logic                 ovf_q, add_q, del_q, tick_q, nowslot_q;
  logic                 removed_q, inserted_q;
  logic [EW-1:0]        carry_q;
  logic                 carry_v_q;
  logic                 pend_v_q;
  logic [7:0]           pend_h_q, pend_g_q;
  logic [15:0]          pend_o_q;
  logic                 imm_v_q;
  logic [7:0]           imm_h_q;
  logic [15:0]          imm_o_q;
  logic [2:0]           res_st_q;

  logic [TIME_BITS-1:0] e_dl;
  logic [7:0]           e_h, e_g;
  logic [15:0]          e_o;
  logic [TIME_BITS:0]   sum;
  logic                 is_now, drop, ins, have_first, hit, tail_busy, out_free;
  logic [EW-1:0]        new_e, first_e, wdata;
  logic                 we, push_mid;

  assign e_dl = rd_q[EW-1:32];
  assign e_h  = rd_q[31:24];
  assign e_o  = rd_q[23:8];
  assign e_g  = rd_q[7:0];

  assign sum    = {1'b0, time_q} + (TIME_BITS + 1)'(delay_i);
  assign is_now = (command_i == sto_pkg::CMD_ADD_NOW);
  assign new_e  = {when_q, cb_q, ow_q, grp_q};
  assign hit    = (e_h == cb_q) && (e_o == ow_q);

  always_comb begin
    drop = 1'b0;
    ins  = 1'b0;
    if (add_q) begin
      drop = !removed_q && hit;
      ins  = !drop && !inserted_q && (e_dl > when_q);
    end else if (del_q) begin
      drop = ((grp_q == 8'd0) || (e_g == grp_q)) && (e_o == ow_q) &&
             ((cb_q == 8'd0) || (e_h == cb_q));
    end else if (tick_q) begin
      drop = (e_dl < time_q);
    end
  end

  // The carried entry goes out first; when an insertion lands here the
  // scanned entry is held back one slot.
  assign have_first = carry_v_q || ins || !drop;
  assign first_e    = carry_v_q ? carry_q : (ins ? new_e : rd_q);
  assign tail_busy  = carry_v_q || (add_q && !inserted_q);
  assign out_free   = !out_valid_o || out_ready_i;
  assign push_mid   = cmd_i.proc && tick_q && drop && pend_v_q;

  assign we    = (cmd_i.proc && have_first) || (cmd_i.tail && tail_busy);
  assign wdata = cmd_i.tail ? (carry_v_q ? carry_q : new_e) : first_e;

  always_comb begin
    stat_o             = '0;
    stat_o.skip        = ovf_q || nowslot_q;
    stat_o.need_search = add_q && (cnt_q == CW'(ENTRIES));
    stat_o.hit         = hit;
    stat_o.last_elem   = (r_q + CW'(1)) >= cnt_q;
    stat_o.more        = r_q < cnt_q;
    stat_o.stall       = tick_q && drop && pend_v_q && !out_free;
    stat_o.tail_busy   = tail_busy;
    stat_o.out_free    = out_free;
    stat_o.carry_v     = carry_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem[r_q[IW-1:0]];
    end
    if (we) begin
      mem[w_q[IW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      when_q      <= '0;
      cnt_q       <= '0;
      r_q         <= '0;
      w_q         <= '0;
      cb_q        <= '0;
      grp_q       <= '0;
      ow_q        <= '0;
      ovf_q       <= 1'b0;
      add_q       <= 1'b0;
      del_q       <= 1'b0;
      tick_q      <= 1'b0;
      nowslot_q   <= 1'b0;
      removed_q   <= 1'b0;
      inserted_q  <= 1'b0;
      carry_q     <= '0;
      carry_v_q   <= 1'b0;
      pend_v_q    <= 1'b0;
      pend_h_q    <= '0;
      pend_o_q    <= '0;
      pend_g_q    <= '0;
      imm_v_q     <= 1'b0;
      imm_h_q     <= '0;
      imm_o_q     <= '0;
      res_st_q    <= sto_pkg::ST_DONE;
      out_valid_o <= 1'b0;
      status_o    <= '0;
      fired_callback_o <= '0;
      fired_owner_o    <= '0;
      fired_queue_o    <= '0;
      last_o      <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cb_q       <= callback_tag_i;
        ow_q       <= owner_tag_i;
        grp_q      <= is_now ? 8'd0 : queue_id_i;
        when_q     <= is_now ? time_q : sum[TIME_BITS-1:0];
        ovf_q      <= (command_i == sto_pkg::CMD_ADD) && sum[TIME_BITS];
        res_st_q   <= ((command_i == sto_pkg::CMD_ADD) && sum[TIME_BITS]) ?
                      sto_pkg::ST_OVERFLOW : sto_pkg::ST_DONE;
        add_q      <= (command_i == sto_pkg::CMD_ADD) || (is_now && imm_v_q);
        del_q      <= (command_i == sto_pkg::CMD_DELETE);
        tick_q     <= (command_i == sto_pkg::CMD_TICK);
        nowslot_q  <= is_now && !imm_v_q;
        removed_q  <= 1'b0;
        inserted_q <= 1'b0;
        carry_v_q  <= 1'b0;
        r_q        <= '0;
        w_q        <= '0;
        pend_v_q   <= (command_i == sto_pkg::CMD_TICK) && imm_v_q;
        if (is_now && !imm_v_q) begin
          imm_v_q <= 1'b1;
          imm_h_q <= callback_tag_i;
          imm_o_q <= owner_tag_i;
        end
        if (command_i == sto_pkg::CMD_TICK) begin
          time_q   <= time_q + TIME_BITS'(1);
          pend_h_q <= imm_h_q;
          pend_o_q <= imm_o_q;
          pend_g_q <= 8'd0;
          imm_v_q  <= 1'b0;
        end
      end
      if (cmd_i.rewind) begin
        r_q <= '0;
      end else if (cmd_i.search) begin
        r_q <= r_q + CW'(1);
      end
      if (cmd_i.set_full) begin
        res_st_q <= sto_pkg::ST_FULL;
      end
      if (cmd_i.proc) begin
        r_q <= r_q + CW'(1);
        if (have_first) begin
          w_q <= w_q + CW'(1);
        end
        carry_v_q <= (carry_v_q || ins) && !drop;
        carry_q   <= rd_q;
        if (add_q && drop) begin
          removed_q <= 1'b1;
        end
        if (ins) begin
          inserted_q <= 1'b1;
        end
        if (tick_q && drop) begin
          pend_v_q <= 1'b1;
          pend_h_q <= e_h;
          pend_o_q <= e_o;
          pend_g_q <= e_g;
        end
      end
      if (cmd_i.tail && tail_busy) begin
        w_q        <= w_q + CW'(1);
        carry_v_q  <= 1'b0;
        inserted_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        cnt_q <= w_q;
      end

      if (push_mid) begin
        out_valid_o      <= 1'b1;
        status_o         <= sto_pkg::ST_EXPIRED;
        fired_callback_o <= pend_h_q;
        fired_owner_o    <= pend_o_q;
        fired_queue_o    <= pend_g_q;
        last_o           <= 1'b0;
      end else if (cmd_i.finish) begin
        out_valid_o <= 1'b1;
        last_o      <= 1'b1;
        if (tick_q && pend_v_q) begin
          status_o         <= sto_pkg::ST_EXPIRED;
          fired_callback_o <= pend_h_q;
          fired_owner_o    <= pend_o_q;
          fired_queue_o    <= pend_g_q;
        end else begin
          status_o         <= tick_q ? sto_pkg::ST_NONE : res_st_q;
          fired_callback_o <= '0;
          fired_owner_o    <= '0;
          fired_queue_o    <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/sorted_timeout_queue.sv -----
// Top level of the sorted timeout queue: controller, datapath and checks.
// The table holds up to ENTRIES timeouts in deadline order in a single-port-write,
// registered-read memory, plus one immediate slot. Each command is handled by one
// pass over the occupied entries, each entry taking a memory read, then a compare
// and compacting write. The final result is loaded at the end of the pass, after
// an extra tail write when an add lands behind the last entry or pushes the last
// entry back one slot; an overflowing add and an add immediate into a free slot
// skip the pass. An add into a full table first makes a read-only search pass over
// up to ENTRIES entries for one to replace; with no entry to replace it ends after
// that search. A tick returns one transfer per expired entry, the immediate slot
// first, and the pass waits while the output is held. The memory needs no clearing
// after reset. The controller is ready for a new command once the final result of
// the previous one has been loaded into the output register.
module sorted_timeout_queue #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  callback_tag_i,
  input  logic [15:0] owner_tag_i,
  input  logic [7:0]  queue_id_i,
  input  logic [31:0] delay_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  fired_callback_o,
  output logic [15:0] fired_owner_o,
  output logic [7:0]  fired_queue_o,
  output logic        last_o
);

  sto_pkg::sto_cmd_t  cmd;
  sto_pkg::sto_stat_t stat;

  sto_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sto_dp #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .command_i        (command_i),
    .callback_tag_i   (callback_tag_i),
    .owner_tag_i      (owner_tag_i),
    .queue_id_i       (queue_id_i),
    .delay_i          (delay_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .fired_callback_o (fired_callback_o),
    .fired_owner_o    (fired_owner_o),
    .fired_queue_o    (fired_queue_o),
    .last_o           (last_o)
  );

`ifndef SYNTH
  // A command is never taken back to back; after an accept the controller leaves idle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Every pass flushes its held-back entry before the next command is taken.
  a_carry_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.carry_v)
    else $error("held-back entry left over between commands");

  // An intermediate tick result is only loaded while the datapath scans entries.
  a_mid_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("non-final result pending while idle");
`endif

endmodule
